[sv/ifd_pkg.sv]
// Shared types and constants for the frame deframer.
package ifd_pkg;

  // Fixed header geometry and the magic word it must start with.
  localparam int unsigned FIXED_BYTES = 16;
  localparam logic [31:0] FRAME_MAGIC = 32'h4549_5043;

  // Section tags on a result.
  localparam logic [1:0] SEC_HEADER  = 2'd0;
  localparam logic [1:0] SEC_PAYLOAD = 2'd1;
  localparam logic [1:0] SEC_MAC     = 2'd2;
  localparam logic [1:0] SEC_STATUS  = 2'd3;

  // Frame status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAGIC   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_LARGE   = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
  localparam logic [1:0] REG_MAX_HEADER       = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd2;
  localparam logic [1:0] REG_MAC_FLAG_MASK    = 2'd3;

  // Reset values of the registers.
  localparam logic [15:0] RST_EXPECTED_VERSION = 16'd1;
  localparam logic [15:0] RST_MAX_HEADER       = 16'd4096;
  localparam logic [23:0] RST_MAX_PAYLOAD      = 24'd65536;
  localparam logic [7:0]  RST_MAC_FLAG_MASK    = 8'd1;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  section;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] header_length;
    logic [23:0] payload_length;
    logic        frame_done;
    logic [2:0]  status;
  } ifd_result_t;

endpackage

[sv/ipc_frame_deframer_unit.sv]
// Streaming deframer: fixed header decode, section tagging and frame status.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   input    in_valid/in_ready    in_byte, end_of_buffer
//   output   out_valid/out_ready  section, out_byte, frame_type, frame_flags,
//                                 header_length, payload_length, frame_done,
//                                 status
//   config   APB (psel..pready)   expected_version, max_header, max_payload,
//                                 mac_flag_mask at byte addresses 0, 4, 8, 12
//
// Each byte is decoded in the cycle it is accepted; its result (if any) goes to
// the output register, or to the skid entry if that is held, so one byte per
// cycle is sustained while the skid entry is empty. The rate is set by the single
// decode step per byte on the phase, position and remaining-count registers.
// A two-entry output stage (output register plus skid register) lets a byte be
// accepted while a result waits; in_ready drops only while the skid entry holds.
// Reset is synchronous: it returns the decoder to collecting a fixed header,
// empties the output stage and restores the register defaults.
module ipc_frame_deframer_unit #(
  parameter int MAC_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  // Result stream.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  section,
  output logic [7:0]  out_byte,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [15:0] header_length,
  output logic [23:0] payload_length,
  output logic        frame_done,
  output logic [2:0]  status,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ifd_pkg::*;

  // The remaining counter must hold the largest payload length (24 bits) and
  // the MAC length.
  localparam int MAC_W = $clog2(MAC_BYTES + 1);
  localparam int REM_W = (MAC_W > 24) ? MAC_W : 24;
  localparam logic [REM_W-1:0] MAC_COUNT = REM_W'(MAC_BYTES);
  localparam logic [3:0] LAST_FIXED = 4'(FIXED_BYTES - 1);

  // Decoder phases: fixed header, the three data sections, and dropping
  // trailing bytes until the end of the buffer.
  typedef enum logic [2:0] {
    PH_FIXED,
    PH_HDR,
    PH_PAY,
    PH_MAC,
    PH_DRAIN
  } phase_t;

  // Configuration registers.
  logic [15:0] expected_version;
  logic [15:0] max_header;
  logic [23:0] max_payload;
  logic [7:0]  mac_flag_mask;

  // Decoder state.
  phase_t           phase, phase_next;
  logic [3:0]       fixed_position, fixed_position_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [31:0]      magic_shift, magic_shift_next;
  logic [15:0]      version_seen, version_seen_next;
  logic [7:0]       type_seen, type_seen_next;
  logic [7:0]       flags_seen, flags_seen_next;
  logic [31:0]      header_len_seen, header_len_seen_next;
  logic [31:0]      payload_len_seen, payload_len_seen_next;

  // Output stage: the output register and the skid entry behind it.
  ifd_result_t out_q;
  ifd_result_t skid_q;
  logic        skid_valid;

  // Result of the byte in flight.
  ifd_result_t res;
  logic        res_emit;
  logic        in_accept;
  logic        cfg_write;
  logic        mac_on;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign mac_on    = (flags_seen_next & mac_flag_mask) != 8'd0;

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_EXPECTED_VERSION: prdata = {16'd0, expected_version};
      REG_MAX_HEADER:       prdata = {16'd0, max_header};
      REG_MAX_PAYLOAD:      prdata = {8'd0, max_payload};
      REG_MAC_FLAG_MASK:    prdata = {24'd0, mac_flag_mask};
      default:              prdata = 32'd0;
    endcase
  end

  // Per-byte decode. Header fields are taken from their next values so that
  // the checks on the last fixed byte see that byte already shifted in.
  always_comb begin
    phase_next            = phase;
    fixed_position_next   = fixed_position;
    remaining_next        = remaining;
    magic_shift_next      = magic_shift;
    version_seen_next     = version_seen;
    type_seen_next        = type_seen;
    flags_seen_next       = flags_seen;
    header_len_seen_next  = header_len_seen;
    payload_len_seen_next = payload_len_seen;
    res_emit              = 1'b0;
    res                   = '0;

    unique case (phase)
      PH_FIXED: begin
        // Field capture by position within the fixed header.
        if (fixed_position < 4'd4) begin
          magic_shift_next = {magic_shift[23:0], in_byte};
        end else if (fixed_position < 4'd6) begin
          version_seen_next = {version_seen[7:0], in_byte};
        end else if (fixed_position == 4'd6) begin
          type_seen_next = in_byte;
        end else if (fixed_position == 4'd7) begin
          flags_seen_next = in_byte;
        end else if (fixed_position < 4'd12) begin
          header_len_seen_next = {header_len_seen[23:0], in_byte};
        end else begin
          payload_len_seen_next = {payload_len_seen[23:0], in_byte};
        end

        res.section = SEC_STATUS;
        res.frame_done = 1'b1;
        if (fixed_position != LAST_FIXED) begin
          if (end_of_buffer) begin
            // Buffer ended inside the fixed header.
            res_emit = 1'b1;
            res.status = ST_TRUNC;
            fixed_position_next = 4'd0;
          end else begin
            fixed_position_next = fixed_position + 4'd1;
          end
        end else begin
          fixed_position_next = 4'd0;
          phase_next = end_of_buffer ? PH_FIXED : PH_DRAIN;
          if (magic_shift_next != FRAME_MAGIC) begin
            res_emit = 1'b1;
            res.status = ST_MAGIC;
          end else if (version_seen_next != expected_version) begin
            res_emit = 1'b1;
            res.status = ST_VERSION;
          end else if (header_len_seen_next > {16'd0, max_header} ||
                       payload_len_seen_next > {8'd0, max_payload}) begin
            res_emit = 1'b1;
            res.status = ST_LARGE;
            res.frame_type = type_seen_next;
            res.frame_flags = flags_seen_next;
          end else begin
            res.frame_type = type_seen_next;
            res.frame_flags = flags_seen_next;
            res.header_length = header_len_seen_next[15:0];
            res.payload_length = payload_len_seen_next[23:0];
            if (header_len_seen_next == 32'd0 && payload_len_seen_next == 32'd0 &&
                !mac_on) begin
              // Empty frame: done on the last fixed byte.
              res_emit = 1'b1;
              res.status = ST_OK;
            end else if (end_of_buffer) begin
              res_emit = 1'b1;
              res.status = ST_TRUNC;
              phase_next = PH_FIXED;
            end else if (header_len_seen_next != 32'd0) begin
              phase_next = PH_HDR;
              remaining_next = REM_W'(header_len_seen_next[15:0]);
            end else if (payload_len_seen_next != 32'd0) begin
              phase_next = PH_PAY;
              remaining_next = REM_W'(payload_len_seen_next[23:0]);
            end else begin
              phase_next = PH_MAC;
              remaining_next = MAC_COUNT;
            end
          end
        end
      end

      PH_HDR, PH_PAY, PH_MAC: begin
        res_emit = 1'b1;
        res.out_byte = in_byte;
        res.frame_type = type_seen;
        res.frame_flags = flags_seen;
        res.header_length = header_len_seen[15:0];
        res.payload_length = payload_len_seen[23:0];
        res.status = ST_OK;
        unique case (phase)
          PH_HDR:  res.section = SEC_HEADER;
          PH_PAY:  res.section = SEC_PAYLOAD;
          default: res.section = SEC_MAC;
        endcase
        remaining_next = remaining - REM_W'(1);

        if (remaining == REM_W'(1)) begin
          // Last byte of this section: pick the next non-empty section.
          priority if (phase == PH_HDR && payload_len_seen != 32'd0) begin
            phase_next = PH_PAY;
            remaining_next = REM_W'(payload_len_seen[23:0]);
          end else if (phase != PH_MAC && mac_on) begin
            phase_next = PH_MAC;
            remaining_next = MAC_COUNT;
          end else begin
            // Frame complete; trailing bytes are dropped.
            phase_next = end_of_buffer ? PH_FIXED : PH_DRAIN;
            res.frame_done = 1'b1;
          end
          if (end_of_buffer && !res.frame_done) begin
            phase_next = PH_FIXED;
            res.frame_done = 1'b1;
            res.status = ST_TRUNC;
          end
        end else if (end_of_buffer) begin
          phase_next = PH_FIXED;
          res.frame_done = 1'b1;
          res.status = ST_TRUNC;
        end
      end

      default: begin
        if (end_of_buffer) begin
          phase_next = PH_FIXED;
        end
      end
    endcase
  end

  // State, configuration and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= RST_EXPECTED_VERSION;
      max_header       <= RST_MAX_HEADER;
      max_payload      <= RST_MAX_PAYLOAD;
      mac_flag_mask    <= RST_MAC_FLAG_MASK;
      phase            <= PH_FIXED;
      fixed_position   <= 4'd0;
      remaining        <= '0;
      magic_shift      <= '0;
      version_seen     <= '0;
      type_seen        <= '0;
      flags_seen       <= '0;
      header_len_seen  <= '0;
      payload_len_seen <= '0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_EXPECTED_VERSION: expected_version <= pwdata[15:0];
          REG_MAX_HEADER:       max_header       <= pwdata[15:0];
          REG_MAX_PAYLOAD:      max_payload      <= pwdata[23:0];
          REG_MAC_FLAG_MASK:    mac_flag_mask    <= pwdata[7:0];
          default:              ;
        endcase
      end

      if (in_accept) begin
        phase            <= phase_next;
        fixed_position   <= fixed_position_next;
        remaining        <= remaining_next;
        magic_shift      <= magic_shift_next;
        version_seen     <= version_seen_next;
        type_seen        <= type_seen_next;
        flags_seen       <= flags_seen_next;
        header_len_seen  <= header_len_seen_next;
        payload_len_seen <= payload_len_seen_next;
      end

      // The skid entry refills the output register first; a new result goes
      // to the output register when it is free, else to the skid entry.
      if (skid_valid) begin
        if (out_ready) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end
      end else if (in_accept && res_emit) begin
        if (!out_valid || out_ready) begin
          out_q     <= res;
          out_valid <= 1'b1;
        end else begin
          skid_q     <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign section        = out_q.section;
  assign out_byte       = out_q.out_byte;
  assign frame_type     = out_q.frame_type;
  assign frame_flags    = out_q.frame_flags;
  assign header_length  = out_q.header_length;
  assign payload_length = out_q.payload_length;
  assign frame_done     = out_q.frame_done;
  assign status         = out_q.status;

endmodule
